/* rtl/core/ihex_pkg.sv */
// Shared types, constants and helpers of the Intel HEX record encoder.
`timescale 1ns / 1ps
`default_nettype none

package ihex_pkg;

    // Record geometry
    localparam int RECORD_BYTES = 32;
    localparam int COUNT_BITS   = 24;
    localparam int RL_W         = $clog2(RECORD_BYTES + 1);

    // Job queue between front and back
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    typedef logic [0:0] t_cfg_index;
    localparam t_cfg_index CFG_START_ADDR = 1'b0;
    localparam t_cfg_index CFG_BYTE_COUNT = 1'b1;

    // ASCII characters
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_F     = 8'h46;

    // Type 04 checksum base: byte count 02 + record type 04
    localparam logic [7:0] SEG_SUM_BASE = 8'h06;

    // Last character position of each record part
    localparam logic [3:0] SEG_LAST_POS  = 4'd15;  // :02000004HHHHCC LF
    localparam logic [3:0] HDR_LAST_POS  = 4'd8;   // :NNAAAA00
    localparam logic [3:0] DAT_LAST_POS  = 4'd1;   // DD
    localparam logic [3:0] TAIL_LAST_POS = 4'd2;   // CC LF
    localparam logic [3:0] EOF_LAST_POS  = 4'd11;  // :00000001FF LF

    // One input byte's worth of text, as decided by the front
    typedef struct packed {
        logic            seg;       // extended linear address record first
        logic [15:0]     high;
        logic [7:0]      seg_sum;   // checksum of the type 04 record
        logic            hdr;       // data record header
        logic [RL_W-1:0] rec_len;
        logic [15:0]     low;
        logic [7:0]      data;
        logic            tail;      // data record checksum and LF
        logic [7:0]      tail_sum;
        logic            eof;       // end-of-file record
    } t_job;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        hex_char = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ihex_if.sv */
// Stream interfaces: raw dump bytes in, hex text characters out.
`timescale 1ns / 1ps
`default_nettype none

interface ihex_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface ihex_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_last;
    logic       dump_done;

    modport source (output valid, output out_char, output run_last, output dump_done,
                    input ready);
    modport sink   (input valid, input out_char, input run_last, input dump_done,
                    output ready);
endinterface

`default_nettype wire

/* rtl/core/ihex_front.sv */
// Front: config registers, dump/record bookkeeping, one job per accepted byte.
`timescale 1ns / 1ps
`default_nettype none

module ihex_front
    import ihex_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire t_cfg_index  i_cfg_index,
    input  wire logic [31:0] i_cfg_wdata,
    ihex_byte_if.sink        i_byte,
    input  wire logic        i_q_full,
    output logic             o_push,
    output t_job             o_job
);

    logic [31:0]           r_start_addr;
    logic [COUNT_BITS-1:0] r_byte_count;
    logic                  r_in_dump,     n_in_dump;
    logic [31:0]           r_cur_addr,    n_cur_addr;
    logic [COUNT_BITS-1:0] r_bytes_left,  n_bytes_left;
    logic [RL_W-1:0]       r_record_left, n_record_left;
    logic [7:0]            r_record_sum,  n_record_sum;
    logic                  r_seg_pending, n_seg_pending;

    logic [31:0]           cur_addr;
    logic [COUNT_BITS-1:0] bytes_left;
    logic [RL_W-1:0]       rec_left;
    logic [7:0]            rec_sum;
    logic                  seg_pend;
    logic [15:0]           low;
    logic [15:0]           high;
    logic                  open_rec;
    logic                  seg;
    logic [RL_W-1:0]       limit;
    logic [16:0]           gap;
    logic [RL_W-1:0]       rec_len;
    logic [RL_W-1:0]       left0;
    logic [7:0]            sum0;
    logic [7:0]            sum1;
    logic [RL_W-1:0]       left1;
    logic [31:0]           addr1;
    logic                  last;
    logic                  close_rec;
    logic                  accept;

    assign i_byte.ready = !i_q_full;
    assign accept       = i_byte.valid && !i_q_full;
    assign o_push       = accept;

    always_comb begin
        // a new dump loads its start point from the registers
        cur_addr   = r_in_dump ? r_cur_addr    : r_start_addr;
        bytes_left = r_in_dump ? r_bytes_left  : r_byte_count;
        rec_left   = r_in_dump ? r_record_left : '0;
        rec_sum    = r_in_dump ? r_record_sum  : '0;
        seg_pend   = r_in_dump ? r_seg_pending : 1'b1;

        low      = cur_addr[15:0];
        high     = cur_addr[31:16];
        open_rec = (rec_left == '0);
        seg      = open_rec && (seg_pend || (low == 16'h0000));

        // record length: full record, dump tail, or up to the 64 KiB boundary
        if ((bytes_left != '0) && (bytes_left < COUNT_BITS'(RECORD_BYTES))) begin
            limit = bytes_left[RL_W-1:0];
        end else begin
            limit = RL_W'(RECORD_BYTES);
        end
        gap = 17'h10000 - {1'b0, low};
        if (gap < 17'(limit)) begin
            rec_len = gap[RL_W-1:0];
        end else begin
            rec_len = limit;
        end

        left0 = open_rec ? rec_len : rec_left;
        sum0  = open_rec ? (8'(rec_len) + low[7:0] + low[15:8]) : rec_sum;
        sum1  = sum0 + i_byte.data_byte;
        left1 = left0 - 1'b1;
        addr1 = cur_addr + 32'd1;
        last  = (bytes_left == COUNT_BITS'(1));
        close_rec = (left1 == '0) || last;

        n_in_dump     = !last;
        n_cur_addr    = addr1;
        n_bytes_left  = bytes_left - 1'b1;
        n_record_left = close_rec ? '0 : left1;
        n_record_sum  = last ? 8'h00 : sum1;
        n_seg_pending = seg ? 1'b0 : seg_pend;
        if ((close_rec && (addr1[15:0] == 16'h0000)) || last) begin
            n_seg_pending = 1'b1;
        end

        o_job.seg      = seg;
        o_job.high     = high;
        o_job.seg_sum  = 8'h00 - (SEG_SUM_BASE + high[7:0] + high[15:8]);
        o_job.hdr      = open_rec;
        o_job.rec_len  = rec_len;
        o_job.low      = low;
        o_job.data     = i_byte.data_byte;
        o_job.tail     = close_rec;
        o_job.tail_sum = 8'h00 - sum1;
        o_job.eof      = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_addr  <= '0;
            r_byte_count  <= COUNT_BITS'(1);
            r_in_dump     <= 1'b0;
            r_cur_addr    <= '0;
            r_bytes_left  <= '0;
            r_record_left <= '0;
            r_record_sum  <= '0;
            r_seg_pending <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_START_ADDR: r_start_addr <= i_cfg_wdata;
                    CFG_BYTE_COUNT: r_byte_count <= i_cfg_wdata[COUNT_BITS-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_in_dump     <= n_in_dump;
                r_cur_addr    <= n_cur_addr;
                r_bytes_left  <= n_bytes_left;
                r_record_left <= n_record_left;
                r_record_sum  <= n_record_sum;
                r_seg_pending <= n_seg_pending;
            end
        end
    end

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_dump |-> ((r_record_left == '0) && r_seg_pending))
        else $error("front idle with a record still open");

endmodule

`default_nettype wire

/* rtl/core/ihex_queue.sv */
// Short job queue that decouples the front from the character back end.
`timescale 1ns / 1ps
`default_nettype none

module ihex_queue
    import ihex_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_job      o_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("job queue underflow");

endmodule

`default_nettype wire

/* rtl/core/ihex_back.sv */
// Back end: walks the head job one character per cycle, while the character output is ready, into an output register.
`timescale 1ns / 1ps
`default_nettype none

module ihex_back
    import ihex_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_valid,
    input  wire t_job   i_job,
    output logic        o_pop,
    ihex_char_if.source o_char
);

    typedef enum logic [4:0] {
        PH_SEG  = 5'b00001,
        PH_HDR  = 5'b00010,
        PH_DAT  = 5'b00100,
        PH_TAIL = 5'b01000,
        PH_EOF  = 5'b10000
    } t_phase;

    logic       r_busy;
    t_phase     r_phase;
    logic [3:0] r_pos;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_last;
    logic       r_out_done;

    t_phase     start_phase;
    t_phase     cur_phase;
    t_phase     nxt_phase;
    logic [3:0] cur_pos;
    logic [3:0] last_pos;
    logic       at_end;
    logic       job_end;
    logic       load;
    logic [7:0] ch;
    logic [7:0] len8;

    assign start_phase = i_job.seg ? PH_SEG : (i_job.hdr ? PH_HDR : PH_DAT);
    assign cur_phase   = r_busy ? r_phase : start_phase;
    assign cur_pos     = r_busy ? r_pos : 4'd0;
    assign load        = i_q_valid && (!r_out_valid || o_char.ready);
    assign at_end      = (cur_pos == last_pos);
    assign o_pop       = load && at_end && job_end;
    assign len8        = 8'(i_job.rec_len);

    always_comb begin
        last_pos  = DAT_LAST_POS;
        nxt_phase = PH_DAT;
        job_end   = 1'b0;
        ch        = CH_ZERO;
        unique case (cur_phase)
            PH_SEG: begin
                last_pos  = SEG_LAST_POS;
                nxt_phase = i_job.hdr ? PH_HDR : PH_DAT;
                case (cur_pos)
                    4'd0:    ch = CH_COLON;
                    4'd2:    ch = CH_TWO;
                    4'd8:    ch = CH_FOUR;
                    4'd9:    ch = hex_char(i_job.high[15:12]);
                    4'd10:   ch = hex_char(i_job.high[11:8]);
                    4'd11:   ch = hex_char(i_job.high[7:4]);
                    4'd12:   ch = hex_char(i_job.high[3:0]);
                    4'd13:   ch = hex_char(i_job.seg_sum[7:4]);
                    4'd14:   ch = hex_char(i_job.seg_sum[3:0]);
                    4'd15:   ch = CH_LF;
                    default: ch = CH_ZERO;
                endcase
            end
            PH_HDR: begin
                last_pos  = HDR_LAST_POS;
                nxt_phase = PH_DAT;
                case (cur_pos)
                    4'd0:    ch = CH_COLON;
                    4'd1:    ch = hex_char(len8[7:4]);
                    4'd2:    ch = hex_char(len8[3:0]);
                    4'd3:    ch = hex_char(i_job.low[15:12]);
                    4'd4:    ch = hex_char(i_job.low[11:8]);
                    4'd5:    ch = hex_char(i_job.low[7:4]);
                    4'd6:    ch = hex_char(i_job.low[3:0]);
                    default: ch = CH_ZERO;
                endcase
            end
            PH_DAT: begin
                last_pos  = DAT_LAST_POS;
                nxt_phase = i_job.tail ? PH_TAIL : PH_EOF;
                job_end   = !i_job.tail && !i_job.eof;
                ch = (cur_pos == 4'd0) ? hex_char(i_job.data[7:4])
                                       : hex_char(i_job.data[3:0]);
            end
            PH_TAIL: begin
                last_pos  = TAIL_LAST_POS;
                nxt_phase = PH_EOF;
                job_end   = !i_job.eof;
                case (cur_pos)
                    4'd0:    ch = hex_char(i_job.tail_sum[7:4]);
                    4'd1:    ch = hex_char(i_job.tail_sum[3:0]);
                    default: ch = CH_LF;
                endcase
            end
            PH_EOF: begin
                last_pos  = EOF_LAST_POS;
                nxt_phase = PH_EOF;
                job_end   = 1'b1;
                case (cur_pos)
                    4'd0:    ch = CH_COLON;
                    4'd8:    ch = CH_ONE;
                    4'd9:    ch = CH_F;
                    4'd10:   ch = CH_F;
                    4'd11:   ch = CH_LF;
                    default: ch = CH_ZERO;
                endcase
            end
            default: begin
                last_pos  = DAT_LAST_POS;
                nxt_phase = PH_DAT;
                job_end   = 1'b1;
                ch        = CH_ZERO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_char <= ch;
            r_out_last <= o_pop;
            r_out_done <= o_pop && (cur_phase == PH_EOF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_SEG;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                if (at_end) begin
                    r_busy  <= !job_end;
                    r_phase <= nxt_phase;
                    r_pos   <= '0;
                end else begin
                    r_busy  <= 1'b1;
                    r_phase <= cur_phase;
                    r_pos   <= cur_pos + 1'b1;
                end
            end else if (o_char.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_char.valid     = r_out_valid;
    assign o_char.out_char  = r_out_char;
    assign o_char.run_last  = r_out_last;
    assign o_char.dump_done = r_out_done;

    a_busy_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> i_q_valid)
        else $error("back end mid-job with empty queue");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> r_out_last)
        else $error("end-of-file flag without end-of-run flag");

    a_eof_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_valid && i_job.eof) |-> i_job.tail)
        else $error("end-of-file job leaves a data record open");

endmodule

`default_nettype wire

/* rtl/core/intel_hex_record_encoder.sv */
// Top level of the Intel HEX record encoder (extended linear address form).
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                              Transfer when
// --------  ---  -----------------------------------  -------------------------
// i_byte    in   data_byte[7:0]                       valid && ready
// o_char    out  out_char[7:0], run_last, dump_done   valid && ready
// i_cfg_*   in   index 0 start_address, 1 byte_count  i_cfg_we (no wait)
//
// Output: the back end sends one character per cycle while o_char.ready allows, and a byte
//   yields 2 to 42 characters (2 in mid-record, about 2.4 averaged over full
//   32-byte records); the character output register sets that pace.
// The front takes a byte in the cycle it arrives while the 2-entry job queue has room.
// Reset: i_rst_n synchronous, active low; no clearing pass.
// Stalls: o_char.ready low holds the output register; the queue then fills and
//   i_byte.ready drops. Bytes and characters keep flowing otherwise.

module intel_hex_record_encoder
    import ihex_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire t_cfg_index  i_cfg_index,
    input  wire logic [31:0] i_cfg_wdata,
    ihex_byte_if.sink        i_byte,
    ihex_char_if.source      o_char
);

    // front -> queue
    logic q_push;
    t_job q_in_job;
    logic q_full;

    // queue -> back
    logic q_valid;
    t_job q_head;
    logic q_pop;

    // Front: dump and record bookkeeping; each transfer becomes one job
    // telling the back end which record parts to print for that byte.
    ihex_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_byte      (i_byte),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (q_in_job)
    );

    // Jobs wait here so byte intake and character output stall independently.
    ihex_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_head)
    );

    // Back: type 04 record, data header, byte digits, checksum + LF, EOF line.
    ihex_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (q_head),
        .o_pop     (q_pop),
        .o_char    (o_char)
    );

endmodule

`default_nettype wire
